// ===== hw/rtl/rsn_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and conversion helpers for the RTC snapshot normalizer.
// Depends on nothing; every other file of the block uses it.
package rsn_pkg;

  localparam int unsigned RawW     = 8;
  localparam int unsigned YearW    = 15;
  localparam int unsigned RefYearW = 14;

  localparam logic [RefYearW-1:0] RefYearReset = 14'd2016;

  // Bit positions inside status register B and the raw hour byte.
  localparam int unsigned SbBinIdx  = 2;
  localparam int unsigned SbH24Idx  = 1;
  localparam int unsigned HourPmIdx = 7;

  // Configuration register indexes.
  typedef enum logic {
    CFG_CENTURY_PRESENT = 1'b0,
    CFG_REFERENCE_YEAR  = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [RawW-1:0] century;
    logic [RawW-1:0] year;
    logic [RawW-1:0] month;
    logic [RawW-1:0] day;
    logic [RawW-1:0] hour;
    logic [RawW-1:0] minute;
    logic [RawW-1:0] second;
  } snap_t;

  // One settled snapshot on its way to conversion.
  typedef struct packed {
    snap_t                snap;
    logic [RawW-1:0]      status_b;
    logic                 century_present;
    logic [RefYearW-1:0]  reference_year;
    logic [YearW-1:0]     century_base;
  } item_t;

  // Each nibble weighted as is: high nibble times ten plus low nibble.
  function automatic logic [RawW-1:0] bcd_to_bin(logic [RawW-1:0] v);
    logic [RawW-1:0] hi8;
    logic [RawW-1:0] lo8;
    hi8 = {4'd0, v[7:4]};
    lo8 = {4'd0, v[3:0]};
    return (hi8 << 3) + (hi8 << 1) + lo8;
  endfunction

  // Hour byte: bits 6..4 are the tens, bit 7 is kept as the PM flag.
  function automatic logic [RawW-1:0] hour_bcd_to_bin(logic [RawW-1:0] v);
    logic [6:0] tens;
    logic [6:0] sum;
    tens = {4'd0, v[6:4]};
    sum  = (tens << 3) + (tens << 1) + {3'd0, v[3:0]};
    return {v[HourPmIdx], sum};
  endfunction

  // Value is at most 139, so five conditional subtractions finish it.
  function automatic logic [RawW-1:0] mod24(logic [RawW-1:0] v);
    logic [RawW-1:0] r;
    r = v;
    for (int k = 0; k < 5; k++) begin
      if (r >= 8'd24) begin
        r = r - 8'd24;
      end
    end
    return r;
  endfunction

  function automatic logic [YearW-1:0] times100(logic [RawW-1:0] c);
    logic [YearW-1:0] c15;
    c15 = {7'd0, c};
    return (c15 << 6) + (c15 << 5) + (c15 << 2);
  endfunction

endpackage

// ===== hw/rtl/rsn_capture.sv =====
`timescale 1ns / 1ps
// Snapshot compare against the kept prior snapshot, and the item register
// that holds a settled snapshot for conversion. Uses rsn_pkg.
module rsn_capture (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_busy,
  input  rsn_pkg::snap_t                in_snap,
  input  logic [rsn_pkg::RawW-1:0]      in_status_b,
  input  logic                          cfg_century_present,
  input  logic [rsn_pkg::RefYearW-1:0]  cfg_reference_year,
  output logic                          item_valid,
  input  logic                          item_ready,
  output rsn_pkg::item_t                item
);

  rsn_pkg::snap_t  prior_r, prior_nxt;
  logic            prior_valid_r, prior_valid_nxt;
  logic            item_valid_r, item_valid_nxt;
  rsn_pkg::item_t  item_r, item_nxt;

  rsn_pkg::snap_t  snap_masked;
  logic            match;
  logic            fire;
  logic            settle;
  logic [26:0]     quot_prod;
  logic [7:0]      quot;

  always_comb begin
    snap_masked = in_snap;
    if (!cfg_century_present) begin
      snap_masked.century = '0;
    end
  end

  assign match    = prior_valid_r && (snap_masked == prior_r);
  assign in_ready = !item_valid_r || item_ready;
  assign fire     = in_valid && in_ready;
  assign settle   = fire && !in_busy && match;

  // Reference year divided by 100 through a reciprocal: exact for 14-bit values.
  assign quot_prod = {13'd0, cfg_reference_year} * 27'd5243;
  assign quot      = quot_prod[26:19];

  always_comb begin
    prior_nxt       = prior_r;
    prior_valid_nxt = prior_valid_r;
    item_nxt        = item_r;
    item_valid_nxt  = item_valid_r;
    if (in_ready) begin
      item_valid_nxt = settle;
    end
    if (fire && !in_busy) begin
      if (match) begin
        prior_valid_nxt          = 1'b0;
        item_nxt.snap            = snap_masked;
        item_nxt.status_b        = in_status_b;
        item_nxt.century_present = cfg_century_present;
        item_nxt.reference_year  = cfg_reference_year;
        item_nxt.century_base    = rsn_pkg::times100(quot);
      end else begin
        prior_nxt       = snap_masked;
        prior_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prior_valid_r <= 1'b0;
      item_valid_r  <= 1'b0;
    end else begin
      prior_valid_r <= prior_valid_nxt;
      item_valid_r  <= item_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prior_r <= prior_nxt;
    item_r  <= item_nxt;
  end

  assign item_valid = item_valid_r;
  assign item       = item_r;

  a_mismatch_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !in_busy && !match |=> prior_valid_r)
    else $error("prior snapshot not kept after a mismatch");

  a_match_settles: assert property (@(posedge clk) disable iff (!rst_n)
    settle |=> item_valid_r && !prior_valid_r)
    else $error("matching snapshot did not settle");

  a_busy_ignored: assert property (@(posedge clk) disable iff (!rst_n)
    fire && in_busy |=> $stable(prior_valid_r))
    else $error("busy snapshot changed the prior state");

  a_item_from_settle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(item_valid_r) |-> $past(settle))
    else $error("item appeared without a matching snapshot");

endmodule

// ===== hw/rtl/rsn_convert.sv =====
`timescale 1ns / 1ps
// BCD, 12/24-hour and year conversion of a settled snapshot into the result
// register. Uses rsn_pkg.
module rsn_convert (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         item_valid,
  output logic                         item_ready,
  input  rsn_pkg::item_t               item,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [55:0]                  out_data
);

  logic                           out_valid_r, out_valid_nxt;
  logic [55:0]                    out_data_r, out_data_nxt;

  logic                           bin_mode;
  logic [rsn_pkg::RawW-1:0]       sec, min, hr_pre, hr, day, mon, yr, cen;
  logic [rsn_pkg::YearW-1:0]      year_base, year_full;

  assign item_ready = !out_valid_r || out_ready;
  assign bin_mode   = item.status_b[rsn_pkg::SbBinIdx];

  always_comb begin
    if (bin_mode) begin
      sec    = item.snap.second;
      min    = item.snap.minute;
      hr_pre = item.snap.hour;
      day    = item.snap.day;
      mon    = item.snap.month;
      yr     = item.snap.year;
      cen    = item.snap.century;
    end else begin
      sec    = rsn_pkg::bcd_to_bin(item.snap.second);
      min    = rsn_pkg::bcd_to_bin(item.snap.minute);
      hr_pre = rsn_pkg::hour_bcd_to_bin(item.snap.hour);
      day    = rsn_pkg::bcd_to_bin(item.snap.day);
      mon    = rsn_pkg::bcd_to_bin(item.snap.month);
      yr     = rsn_pkg::bcd_to_bin(item.snap.year);
      cen    = rsn_pkg::bcd_to_bin(item.snap.century);
    end

    // A PM hour in 12-hour mode wraps into the 24-hour range.
    if (!item.status_b[rsn_pkg::SbH24Idx] && hr_pre[rsn_pkg::HourPmIdx]) begin
      hr = rsn_pkg::mod24({1'b0, hr_pre[6:0]} + 8'd12);
    end else begin
      hr = hr_pre;
    end

    year_base = item.century_base + {7'd0, yr};
    if (item.century_present) begin
      year_full = {7'd0, yr} + rsn_pkg::times100(cen);
    end else if (year_base < {1'b0, item.reference_year}) begin
      year_full = year_base + 15'd100;
    end else begin
      year_full = year_base;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (item_ready) begin
      out_valid_nxt = item_valid;
      if (item_valid) begin
        out_data_nxt = {1'b0, year_full, mon, day, hr, min, sec};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    item_valid && item_ready |=> out_valid_r)
    else $error("converted item lost");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !out_data_r[55])
    else $error("padding bit set in result word");

endmodule

// ===== hw/rtl/rtc_snapshot_normalizer.sv =====
`timescale 1ns / 1ps
// RTC snapshot normalizer: one item register after the snapshot compare and
// one result register after conversion. Depends on rsn_pkg, rsn_capture and
// rsn_convert.
//
// Accepts one raw RTC snapshot word per cycle while in_tready is high. A
// word flagged busy is dropped; otherwise it is compared with the kept prior
// snapshot, and only when the two match is a normalized date produced, after
// which the prior is cleared. A matching word passes the item register, then
// the result register, held there until taken; input stalls while both
// registers are full and the result is not taken. The user must write
// configuration only while no word is in flight; the block does not enforce it.
module rtc_snapshot_normalizer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // second, minute, hour, day, month, year, century, status_b
  input  logic [63:0]                   in_tdata,
  // update_busy
  input  logic                          in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // second, minute, hour, day, month, year (15 bits), one zero pad bit
  output logic [55:0]                   out_tdata,
  input  logic                          cfg_we,
  input  rsn_pkg::cfg_idx_t             cfg_index,
  input  logic [rsn_pkg::RefYearW-1:0]  cfg_wdata
);

  logic                          century_present_r, century_present_nxt;
  logic [rsn_pkg::RefYearW-1:0]  reference_year_r, reference_year_nxt;

  rsn_pkg::snap_t                in_snap;
  logic                          item_valid;
  logic                          item_ready;
  rsn_pkg::item_t                item;

  always_comb begin
    century_present_nxt = century_present_r;
    reference_year_nxt  = reference_year_r;
    if (cfg_we) begin
      unique case (cfg_index)
        rsn_pkg::CFG_CENTURY_PRESENT: century_present_nxt = cfg_wdata[0];
        rsn_pkg::CFG_REFERENCE_YEAR:  reference_year_nxt  = cfg_wdata;
        default:                      century_present_nxt = century_present_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      century_present_r <= 1'b0;
      reference_year_r  <= rsn_pkg::RefYearReset;
    end else begin
      century_present_r <= century_present_nxt;
      reference_year_r  <= reference_year_nxt;
    end
  end

  assign in_snap = in_tdata[55:0];

  rsn_capture u_capture (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_tvalid),
    .in_ready            (in_tready),
    .in_busy             (in_tuser),
    .in_snap             (in_snap),
    .in_status_b         (in_tdata[63:56]),
    .cfg_century_present (century_present_r),
    .cfg_reference_year  (reference_year_r),
    .item_valid          (item_valid),
    .item_ready          (item_ready),
    .item                (item)
  );

  rsn_convert u_convert (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (out_tdata)
  );

endmodule
